/* src/apce_pkg.sv */
// ----------------------------------------------------------------------------
// apce_pkg
// Shared types and constants of the audio processor command encoder.
// ----------------------------------------------------------------------------
package apce_pkg;

  // Tuning commands as they arrive on the input.
  typedef enum logic [3:0] {
    CMD_VOLUME   = 4'd0,
    CMD_BASS     = 4'd1,
    CMD_TREBLE   = 4'd2,
    CMD_BALANCE  = 4'd3,
    CMD_FADER    = 4'd4,
    CMD_GAIN     = 4'd5,
    CMD_INPUT    = 4'd6,
    CMD_LOUDNESS = 4'd7,
    CMD_MUTE     = 4'd8
  } cmd_e;

  // Register bases of the audio processor.
  localparam logic [7:0] VOL_BASE    = 8'h00;
  localparam logic [7:0] SP_FL       = 8'h80;
  localparam logic [7:0] SP_FR       = 8'hA0;
  localparam logic [7:0] SP_RL       = 8'hC0;
  localparam logic [7:0] SP_RR       = 8'hE0;
  localparam logic [7:0] MUTE_CODE   = 8'h1F;
  localparam logic [7:0] SWITCH_BASE = 8'h40;
  localparam logic [7:0] BASS_BASE   = 8'h60;
  localparam logic [7:0] TREBLE_BASE = 8'h70;

  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned BIDX_W    = $clog2(MAX_BYTES);

  // Depth of the job queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // One classified command: its bytes in sending order and the index of the last.
  typedef struct packed {
    logic [BIDX_W-1:0]            last_idx;
    logic [MAX_BYTES-1:0][7:0]    bytes;
  } job_t;

endpackage

/* src/apce_front.sv */
// ----------------------------------------------------------------------------
// apce_front
// Accepts commands, keeps the stored settings and builds the byte job.
// ----------------------------------------------------------------------------
module apce_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [3:0]        command_i,
  input  logic signed [6:0] setting_value_i,
  output logic              job_valid_o,
  output apce_pkg::job_t    job_o
);
  import apce_pkg::*;

  logic signed [4:0] balance_q, balance_d;
  logic signed [4:0] fader_q, fader_d;
  logic [1:0]        gain_q, gain_d;
  logic [1:0]        sel_q, sel_d;
  logic              loud_q, loud_d;

  logic signed [6:0] v;
  logic [6:0]        neg_v;
  logic [5:0]        vol_att;
  logic [3:0]        tone;
  logic signed [4:0] lvl_clamp;
  logic [1:0]        sw_clamp;
  logic [4:0]        b_pos, b_neg, f_pos, f_neg;
  logic [4:0]        att_rl, att_rr, att_fl, att_fr;
  logic [7:0]        switch_byte;
  job_t              speakers;
  cmd_e              cmd;

  assign v     = setting_value_i;
  assign neg_v = -v;
  assign cmd   = cmd_e'(command_i);

  always_comb begin
    if (v < -7'sd63) begin
      vol_att = 6'd63;
    end else if (v > 7'sd0) begin
      vol_att = 6'd0;
    end else begin
      vol_att = neg_v[5:0];
    end

    if (v > 7'sd7) begin
      tone = 4'd8;
    end else if (v < -7'sd7) begin
      tone = 4'd0;
    end else if (v > 7'sd0) begin
      tone = 4'd15 - v[3:0];
    end else begin
      tone = 4'd7 + v[3:0];
    end

    if (v > 7'sd15) begin
      lvl_clamp = 5'sd15;
    end else if (v < -7'sd15) begin
      lvl_clamp = -5'sd15;
    end else begin
      lvl_clamp = v[4:0];
    end

    if (v > 7'sd3) begin
      sw_clamp = 2'd3;
    end else if (v < 7'sd0) begin
      sw_clamp = 2'd0;
    end else begin
      sw_clamp = v[1:0];
    end
  end

  // Next values of the stored settings.
  always_comb begin
    balance_d = balance_q;
    fader_d   = fader_q;
    gain_d    = gain_q;
    sel_d     = sel_q;
    loud_d    = loud_q;
    if (accept_i) begin
      unique case (cmd)
        CMD_BALANCE:  balance_d = lvl_clamp;
        CMD_FADER:    fader_d   = lvl_clamp;
        CMD_GAIN:     gain_d    = sw_clamp;
        CMD_INPUT:    sel_d     = sw_clamp;
        CMD_LOUDNESS: loud_d    = (v != 7'sd0);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      balance_q <= '0;
      fader_q   <= '0;
      gain_q    <= '0;
      sel_q     <= '0;
      loud_q    <= 1'b0;
    end else begin
      balance_q <= balance_d;
      fader_q   <= fader_d;
      gain_q    <= gain_d;
      sel_q     <= sel_d;
      loud_q    <= loud_d;
    end
  end

  // Speaker attenuations from the settings as they stand after this command.
  always_comb begin
    b_pos  = (balance_d > 5'sd0) ? balance_d : 5'd0;
    b_neg  = (balance_d > 5'sd0) ? 5'd0 : 5'(-balance_d);
    f_pos  = (fader_d > 5'sd0) ? fader_d : 5'd0;
    f_neg  = (fader_d > 5'sd0) ? 5'd0 : 5'(-fader_d);
    att_rl = b_pos + f_pos;
    att_rr = b_neg + f_pos;
    att_fl = b_pos + f_neg;
    att_fr = b_neg + f_neg;

    speakers.last_idx = BIDX_W'(MAX_BYTES - 1);
    speakers.bytes[0] = SP_RL | {3'b000, att_rl};
    speakers.bytes[1] = SP_RR | {3'b000, att_rr};
    speakers.bytes[2] = SP_FL | {3'b000, att_fl};
    speakers.bytes[3] = SP_FR | {3'b000, att_fr};

    switch_byte = SWITCH_BASE | {3'b000, ~gain_d, loud_d, sel_d};
  end

  always_comb begin
    job_valid_o = accept_i;
    job_o       = '0;
    unique case (cmd)
      CMD_VOLUME:  job_o.bytes[0] = VOL_BASE | {2'b00, vol_att};
      CMD_BASS:    job_o.bytes[0] = BASS_BASE | {4'h0, tone};
      CMD_TREBLE:  job_o.bytes[0] = TREBLE_BASE | {4'h0, tone};
      CMD_BALANCE, CMD_FADER: job_o = speakers;
      CMD_GAIN, CMD_INPUT, CMD_LOUDNESS: job_o.bytes[0] = switch_byte;
      CMD_MUTE: begin
        if (v != 7'sd0) begin
          job_o.last_idx = BIDX_W'(MAX_BYTES - 1);
          job_o.bytes[0] = SP_RL | MUTE_CODE;
          job_o.bytes[1] = SP_RR | MUTE_CODE;
          job_o.bytes[2] = SP_FL | MUTE_CODE;
          job_o.bytes[3] = SP_FR | MUTE_CODE;
        end else begin
          job_o = speakers;
        end
      end
      default: job_valid_o = 1'b0;
    endcase
  end

endmodule

/* src/apce_queue.sv */
// ----------------------------------------------------------------------------
// apce_queue
// Short job queue that decouples the front from the byte sequencer.
// ----------------------------------------------------------------------------
module apce_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  apce_pkg::job_t wr_job_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           empty_o,
  output apce_pkg::job_t rd_job_o
);
  import apce_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o   = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    end
  end

endmodule

/* src/apce_back.sv */
// ----------------------------------------------------------------------------
// apce_back
// Byte sequencer: walks the head job into the output register, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module apce_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  apce_pkg::job_t q_job_i,
  output logic           q_rd_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     command_byte_o,
  output logic           last_byte_o
);
  import apce_pkg::*;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [BIDX_W-1:0] idx_q, idx_d;
  logic              load, is_last;

  // The output register takes a new byte when it is free or being taken.
  assign load    = !q_empty_i && (!out_valid_q || pop_i);
  assign is_last = (idx_q == q_job_i.last_idx);
  assign q_rd_o  = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_last ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= q_job_i.bytes[idx_q];
      last_q <= is_last;
    end
  end

  assign empty_o        = !out_valid_q;
  assign command_byte_o = byte_q;
  assign last_byte_o    = last_q;

endmodule

/* src/audio_processor_command_encoder.sv */
// ----------------------------------------------------------------------------
// audio_processor_command_encoder
// Turns tuning commands into register bytes for a four-speaker audio processor.
// ----------------------------------------------------------------------------
// Both sides look like a queue. A command is transferred in when push is high
// and full is low; each result byte is transferred out when pop is high and
// empty is low, the oldest waiting byte being on command_byte_o/last_byte_o.
// Volume, tone and switch commands yield one byte; balance, fader and mute
// yield four, the final one flagged by last_byte_o. Unknown commands are
// accepted and yield nothing.
// After its transfer in, a command's first byte passes through the job queue
// and then the output register. The byte sequencer sends one byte per cycle
// while the receiver keeps popping. A two-entry job queue lets the front
// take commands back to back while the sequencer is still busy.
// If the receiver stalls, the current byte holds and the queue fills; full
// then rises until bytes are drained again.
// Reset clears the stored balance, fader, gain, input and loudness settings
// to zero and empties the queue and the output register.
// ----------------------------------------------------------------------------
module audio_processor_command_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [3:0]        command_i,
  input  logic signed [6:0] setting_value_i,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        command_byte_o,
  output logic              last_byte_o
);
  import apce_pkg::*;

  logic accept;
  logic job_valid;
  job_t job;
  logic q_empty, q_rd;
  job_t q_job;

  // The queue's full flag gates every transfer in, whatever the command.
  assign accept = push && !full;

  apce_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (command_i),
    .setting_value_i(setting_value_i),
    .job_valid_o    (job_valid),
    .job_o          (job)
  );

  apce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_valid),
    .wr_job_i(job),
    .full_o  (full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rd_job_o(q_job)
  );

  apce_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_job_i       (q_job),
    .q_rd_o        (q_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .command_byte_o(command_byte_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

/* src/apce_checker.sv */
// ----------------------------------------------------------------------------
// apce_checker
// Port-level checks on the result stream of the command encoder.
// ----------------------------------------------------------------------------
module apce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] command_byte_o,
  input logic       last_byte_o
);

  // A waiting byte that is not taken holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(command_byte_o) && $stable(last_byte_o)))
    else $error("stalled result byte changed");

  // Once a run has begun, its next byte follows without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_byte_o) |=> !empty)
    else $error("gap inside a byte run");

  // Only speaker bytes are ever followed by more bytes of the same run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_byte_o) |-> command_byte_o[7])
    else $error("non-speaker byte not flagged as last");

  // The front-right byte always closes a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && command_byte_o[7:5] == 3'b101) |-> last_byte_o)
    else $error("front-right byte not flagged as last");

endmodule

bind audio_processor_command_encoder apce_checker u_apce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .command_byte_o(command_byte_o),
  .last_byte_o   (last_byte_o)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the audio processor command encoder.
// ----------------------------------------------------------------------------
// Tuning commands go in through the push/full side, and register bytes come
// out through the empty/pop side. Every accepted command is run through a
// behavioural model of the encoder. That model keeps its own copy of the
// stored balance, fader, gain, input and loudness settings and queues the
// bytes it expects. Every byte popped from the block is compared with the
// oldest queued byte.
// ----------------------------------------------------------------------------
module testbench;
  import apce_pkg::*;

  // The expected byte stream: one entry per byte that the block must return.
  typedef struct {
    logic [7:0] code;
    logic       last;
  } reg_byte_t;

  // Shadow of the encoder. It predicts the bytes of each accepted command and
  // checks the popped bytes against them in order.
  class command_byte_board;
    reg_byte_t   awaited_bytes[$];
    int          balance;
    int          fader;
    int          gain;
    int          selected;
    int          loudness;
    int          bytes_checked;
    int          mismatches;

    function new();
      balance       = 0;
      fader         = 0;
      gain          = 0;
      selected      = 0;
      loudness      = 0;
      bytes_checked = 0;
      mismatches    = 0;
    endfunction

    function int clip(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void add_byte(logic [7:0] code, logic last);
      reg_byte_t b;
      b.code = code;
      b.last = last;
      awaited_bytes.push_back(b);
    endfunction

    function logic [7:0] tone_code(int v);
      int t;
      t = clip(v, -7, 7);
      return (t > 0) ? 8'(15 - t) : 8'(7 + t);
    endfunction

    function void add_switch_byte();
      add_byte(SWITCH_BASE | 8'(selected) | 8'((3 - gain) << 3) | 8'(loudness << 2), 1'b1);
    endfunction

    // Speaker attenuations from the stored balance and fader.
    function void add_speaker_run();
      int fl, fr, rl, rr;
      fl = 0;
      fr = 0;
      rl = 0;
      rr = 0;
      if (balance > 0) begin
        fl += balance;
        rl += balance;
      end else begin
        fr -= balance;
        rr -= balance;
      end
      if (fader > 0) begin
        rl += fader;
        rr += fader;
      end else begin
        fl -= fader;
        fr -= fader;
      end
      add_byte(SP_RL | 8'(rl), 1'b0);
      add_byte(SP_RR | 8'(rr), 1'b0);
      add_byte(SP_FL | 8'(fl), 1'b0);
      add_byte(SP_FR | 8'(fr), 1'b1);
    endfunction

    function void note_command(logic [3:0] cmd, logic signed [6:0] raw);
      int v;
      v = raw;
      case (cmd)
        CMD_VOLUME:   add_byte(VOL_BASE | 8'(-clip(v, -63, 0)), 1'b1);
        CMD_BASS:     add_byte(BASS_BASE | tone_code(v), 1'b1);
        CMD_TREBLE:   add_byte(TREBLE_BASE | tone_code(v), 1'b1);
        CMD_BALANCE: begin
          balance = clip(v, -15, 15);
          add_speaker_run();
        end
        CMD_FADER: begin
          fader = clip(v, -15, 15);
          add_speaker_run();
        end
        CMD_GAIN: begin
          gain = clip(v, 0, 3);
          add_switch_byte();
        end
        CMD_INPUT: begin
          selected = clip(v, 0, 3);
          add_switch_byte();
        end
        CMD_LOUDNESS: begin
          loudness = (v != 0) ? 1 : 0;
          add_switch_byte();
        end
        CMD_MUTE: begin
          if (v != 0) begin
            add_byte(SP_RL | MUTE_CODE, 1'b0);
            add_byte(SP_RR | MUTE_CODE, 1'b0);
            add_byte(SP_FL | MUTE_CODE, 1'b0);
            add_byte(SP_FR | MUTE_CODE, 1'b1);
          end else begin
            add_speaker_run();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] code, logic last);
      reg_byte_t exp_b;
      if (awaited_bytes.size() == 0) begin
        $error("unexpected byte: command_byte 0x%02h last_byte %0b with nothing awaited",
               code, last);
        mismatches++;
        return;
      end
      exp_b = awaited_bytes.pop_front();
      bytes_checked++;
      if (code !== exp_b.code) begin
        $error("command_byte: expected 0x%02h, actual 0x%02h", exp_b.code, code);
        mismatches++;
      end
      if (last !== exp_b.last) begin
        $error("last_byte: expected %0b, actual %0b", exp_b.last, last);
        mismatches++;
      end
    endfunction
  endclass

  localparam int RANDOM_COMMANDS = 80;
  // Commands from this index on are sent with neither side idling.
  localparam int CALM_FROM       = 65;
  // After this many transfers in, the receiver stops popping for a long time.
  localparam int HOLD_AFTER      = 35;
  localparam int HOLD_CYCLES     = 120;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              push            = 1'b0;
  logic              pop             = 1'b0;
  logic [3:0]        command_i       = 4'd0;
  logic signed [6:0] setting_value_i = 7'sd0;
  logic              full;
  logic              empty;
  logic [7:0]        command_byte_o;
  logic              last_byte_o;

  command_byte_board board = new();

  int commands_sent  = 0;
  int unknown_sent   = 0;
  bit calm           = 1'b0;
  bit long_hold_due  = 1'b0;
  bit long_hold_done = 1'b0;

  audio_processor_command_encoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .setting_value_i (setting_value_i),
    .empty           (empty),
    .pop             (pop),
    .command_byte_o  (command_byte_o),
    .last_byte_o     (last_byte_o)
  );

  always #10 clk_i = ~clk_i;

  // Offers one command and waits for its transfer. Now and then the sender
  // idles first; push is lowered only in that case, so a command that follows
  // straight on keeps push high without a second assignment in the same step.
  task automatic send_command(input logic [3:0] cmd, input logic signed [6:0] val);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push            <= 1'b1;
    command_i       <= cmd;
    setting_value_i <= val;
    // The values read just after the edge are those from before it, so this
    // sees exactly the push/full pair that decided the transfer.
    do @(posedge clk_i); while (full !== 1'b0);
    board.note_command(cmd, val);
    commands_sent++;
    if (cmd > CMD_MUTE) unknown_sent++;
    if (commands_sent == HOLD_AFTER) long_hold_due = 1'b1;
  endtask

  // A setting for the given command: half the time inside the command's own
  // grid, otherwise anywhere in the 7-bit field or at -64, 63, -63 or 15, so
  // that saturation is exercised well.
  function automatic logic signed [6:0] pick_setting(logic [3:0] cmd);
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      case (cmd)
        CMD_VOLUME:                  v = int'($urandom_range(0, 63)) - 63;
        CMD_BASS, CMD_TREBLE:        v = int'($urandom_range(0, 14)) - 7;
        CMD_BALANCE, CMD_FADER:      v = int'($urandom_range(0, 30)) - 15;
        CMD_GAIN, CMD_INPUT:         v = $urandom_range(0, 3);
        default:                     v = $urandom_range(0, 1);
      endcase
    end else if (pick < 8) begin
      v = int'($urandom_range(0, 127)) - 64;
    end else begin
      case ($urandom_range(0, 3))
        0:       v = -64;
        1:       v = 63;
        2:       v = -63;
        default: v = 15;
      endcase
    end
    return 7'(v);
  endfunction

  // Directed opening: ends of the volume and bass grids, saturation on both
  // sides, the largest speaker attenuation, mute and unmute, and unknown commands.
  task automatic run_directed();
    send_command(CMD_VOLUME,   -7'sd63);
    send_command(CMD_VOLUME,   7'sd0);
    send_command(CMD_VOLUME,   7'sd15);
    send_command(CMD_VOLUME,   -7'sd64);
    send_command(CMD_BASS,     -7'sd7);
    send_command(CMD_BASS,     7'sd7);
    send_command(CMD_BASS,     7'sd63);
    send_command(CMD_TREBLE,   -7'sd64);
    send_command(CMD_TREBLE,   7'sd0);
    send_command(CMD_TREBLE,   7'sd3);
    send_command(CMD_BALANCE,  7'sd15);
    send_command(CMD_FADER,    -7'sd15);
    // Balance at -15 and fader at +15 (both saturated) give the largest attenuation.
    send_command(CMD_BALANCE,  -7'sd64);
    send_command(CMD_FADER,    7'sd63);
    send_command(CMD_MUTE,     7'sd1);
    send_command(CMD_MUTE,     7'sd0);
    send_command(CMD_MUTE,     -7'sd1);
    send_command(CMD_GAIN,     -7'sd5);
    send_command(CMD_GAIN,     7'sd63);
    send_command(CMD_INPUT,    7'sd2);
    send_command(CMD_INPUT,    -7'sd64);
    send_command(CMD_LOUDNESS, 7'sd1);
    send_command(CMD_LOUDNESS, -7'sd1);
    send_command(CMD_LOUDNESS, 7'sd0);
    send_command(4'd9,         7'sd5);
    send_command(4'd15,        -7'sd1);
  endtask

  // Random part: known commands with random settings, with an unknown command
  // mixed in now and then. Only known commands count towards the total.
  task automatic run_random();
    int counted;
    logic [3:0] cmd;
    counted = 0;
    while (counted < RANDOM_COMMANDS) begin
      calm = (counted >= CALM_FROM);
      if ($urandom_range(0, 11) == 0) begin
        cmd = 4'($urandom_range(9, 15));
      end else begin
        cmd = 4'($urandom_range(0, 8));
        counted++;
      end
      send_command(cmd, pick_setting(cmd));
    end
  endtask

  // Receiver: pops with random bursts of idling, and once holds off for a long
  // stretch so that the job queue fills up and full is raised. The hold is
  // counted here, cycle by cycle, while the sender keeps offering commands.
  initial begin : receiver
    int idle_left;
    idle_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_due && !long_hold_done) begin
        long_hold_done = 1'b1;
        idle_left      = HOLD_CYCLES;
      end else if (idle_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 11);
      end
      if (idle_left > 0) begin
        pop <= 1'b0;
        idle_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Every byte transfer out is checked against the oldest awaited byte.
  always @(posedge clk_i) begin
    if (rst_ni && pop && empty === 1'b0) begin
      board.check_byte(command_byte_o, last_byte_o);
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    push <= 1'b0;
    // Drain what is still owed, then keep the clock running for stray bytes.
    while (board.awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Coverage: %0d commands transferred in (%0d of them unknown), %0d bytes checked,",
             commands_sent, unknown_sent, board.bytes_checked);
    $display("with random idling on both sides and one long output stall that filled the queue.");
    if (board.mismatches == 0 && board.awaited_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, which is well under 0.2 ms.
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
